/* design/llc_pkg.sv */
// Shared types, codes and frame constants for the lidar link controller.
`default_nettype none

package llc_pkg;

  // Serial frame constants
  localparam logic [7:0] SYNC_BYTE   = 8'd165;
  localparam logic [7:0] PWM_OPCODE  = 8'd240;
  localparam logic [7:0] SCAN_OPCODE = 8'd32;
  localparam logic [7:0] STOP_OPCODE = 8'd37;
  localparam logic [7:0] PWM_LEN     = 8'd2;
  localparam logic [2:0] HEADER_LEN  = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_QUALITY_MIN  = 3'd0;
  localparam logic [2:0] REG_DISTANCE_MIN = 3'd1;
  localparam logic [2:0] REG_START_DELAY  = 3'd2;
  localparam logic [2:0] REG_STOP_DELAY   = 3'd3;
  localparam logic [2:0] REG_MOTOR_PWM    = 3'd4;

  localparam int unsigned CFG_W = 24;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } llc_cmd_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DTR  = 2'd1,
    KIND_MEAS = 2'd2
  } llc_kind_e;

  typedef enum logic [1:0] {
    MODE_STOPPING = 2'd0,
    MODE_OFF      = 2'd1,
    MODE_STARTING = 2'd2,
    MODE_SCANNING = 2'd3
  } llc_mode_e;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_SCAN = 2'd1,
    REQ_OFF  = 2'd2
  } llc_req_e;

  // Kinds of result burst one input item can cause
  typedef enum logic [2:0] {
    BURST_NONE,      // nothing
    BURST_START,     // DTR clear, PWM frame with configured duty
    BURST_PWM0,      // PWM frame with zero duty
    BURST_SCAN,      // scan frame
    BURST_STOP,      // stop frame, PWM frame with zero duty
    BURST_DTR_SET,   // DTR set
    BURST_MEAS       // one accepted measurement
  } llc_burst_e;

  typedef struct packed {
    llc_cmd_e    cmd;
    logic [7:0]  rx_byte;
  } llc_in_t;

  typedef struct packed {
    llc_kind_e          kind;
    logic [7:0]         tx_byte;
    logic               dtr_level;
    logic [5:0]         quality;
    logic signed [15:0] angle;
    logic [15:0]        distance;
    logic               last;
  } llc_out_t;

  // Burst descriptor handed from the mode logic to the frame generator
  typedef struct packed {
    llc_burst_e         burst;
    logic [15:0]        duty;
    logic [5:0]         quality;
    logic signed [15:0] angle;
    logic [15:0]        distance;
  } llc_burst_t;

  // Byte k of a set-PWM frame: sync, opcode, length, duty low, duty high, checksum
  function automatic logic [7:0] pwm_byte(input logic [2:0] k, input logic [15:0] duty);
    logic [7:0] b;
    case (k)
      3'd0:    b = SYNC_BYTE;
      3'd1:    b = PWM_OPCODE;
      3'd2:    b = PWM_LEN;
      3'd3:    b = duty[7:0];
      3'd4:    b = duty[15:8];
      default: b = SYNC_BYTE ^ PWM_OPCODE ^ PWM_LEN ^ duty[7:0] ^ duty[15:8];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* design/lidar_link_controller.sv */
// Top level of the lidar link controller: mode machine, sample decoder and result emitter.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------------
//  in       | to block  | in_valid_i / in_stall_o   | in_item_i  (cmd, rx_byte)
//  out      | from block| out_valid_o / out_stall_i | out_item_o (kind .. last)
//  cfg      | to block  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// An input item is evaluated in the cycle it is accepted: mode, timer, header and
// sample counters update at that edge and the results it causes are captured as one
// burst descriptor. The emitter then drives one result per cycle from that descriptor
// into the output register while out_stall_i is low; the burst length, longest for a
// stop from scanning, sets the rate.
// A new item is taken while the last result of the previous burst still waits in the
// output register. Reset puts the block in stopping mode with no request pending.
`default_nettype none

module lidar_link_controller #(
  parameter int unsigned TIMER_BITS = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire llc_pkg::llc_in_t in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output llc_pkg::llc_out_t     out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [23:0]      cfg_data_i
);
  import llc_pkg::*;

  localparam int unsigned CmpW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // Configuration registers
  logic [5:0]  quality_min_q;
  logic [15:0] distance_min_q;
  logic [23:0] start_delay_q;
  logic [23:0] stop_delay_q;
  logic [15:0] motor_pwm_q;

  // Control state
  llc_mode_e             mode_q, mode_d;
  llc_req_e              req_q, req_d;
  logic [TIMER_BITS-1:0] tick_q, tick_d, tick_inc;
  logic [2:0]            hdr_q, hdr_d;
  logic [2:0]            smp_q, smp_d;

  // Sample byte store
  logic [7:0] smp_mem_q [4];
  logic       smp_we;

  // Burst descriptor and emitter
  logic       desc_valid_q, desc_valid_d;
  llc_burst_t desc_q, desc_d;
  logic [2:0] idx_q, idx_d;
  llc_out_t   gen_item;
  logic       out_load;
  logic       out_valid_q;
  llc_out_t   out_item_q;

  logic in_acc;

  // Decoded sample
  logic [5:0]         dec_quality;
  logic [14:0]        dec_raw;
  logic signed [15:0] dec_angle;
  logic [15:0]        dec_distance;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quality_min_q  <= 6'd10;
      distance_min_q <= 16'd40;
      start_delay_q  <= 24'd1000;
      stop_delay_q   <= 24'd1000;
      motor_pwm_q    <= 16'd660;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_QUALITY_MIN:  quality_min_q  <= cfg_data_i[5:0];
        REG_DISTANCE_MIN: distance_min_q <= cfg_data_i[15:0];
        REG_START_DELAY:  start_delay_q  <= cfg_data_i;
        REG_STOP_DELAY:   stop_delay_q   <= cfg_data_i;
        REG_MOTOR_PWM:    motor_pwm_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a new item once the current burst hands over its last result
  // ---------------------------------------------------------------------------
  assign out_load   = desc_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = desc_valid_q && !(out_load && gen_item.last);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode the sample: quality, angle in 1/64 degree, distance in quarter mm
  assign dec_quality  = smp_mem_q[0][7:2];
  assign dec_raw      = {smp_mem_q[2], smp_mem_q[1][7:1]};
  assign dec_angle    = 16'sd23040 - $signed({1'b0, dec_raw});
  assign dec_distance = {in_item_i.rx_byte, smp_mem_q[3]};

  assign tick_inc = (&tick_q) ? tick_q : tick_q + 1'b1;

  // ---------------------------------------------------------------------------
  // Mode machine: next state and burst for the accepted item
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_d         = mode_q;
    req_d          = req_q;
    tick_d         = tick_q;
    hdr_d          = hdr_q;
    smp_d          = smp_q;
    smp_we         = 1'b0;
    desc_d         = desc_q;
    desc_d.burst   = BURST_NONE;
    desc_d.duty    = '0;

    if (in_acc) begin
      // Apply the command first
      case (in_item_i.cmd)
        CMD_TICK:  tick_d = tick_inc;
        CMD_START: req_d  = REQ_SCAN;
        CMD_STOP:  req_d  = REQ_OFF;
        default: ;
      endcase

      case (mode_q)
        MODE_OFF: begin
          if (req_d == REQ_SCAN) begin
            desc_d.burst = BURST_START;
            desc_d.duty  = motor_pwm_q;
            tick_d       = '0;
            mode_d       = MODE_STARTING;
          end
        end
        MODE_STARTING: begin
          if (req_d == REQ_SCAN) begin
            if (CmpW'(tick_d) > CmpW'(start_delay_q)) begin
              hdr_d        = '0;
              smp_d        = '0;
              desc_d.burst = BURST_SCAN;
              mode_d       = MODE_SCANNING;
            end
          end else if (req_d == REQ_OFF) begin
            desc_d.burst = BURST_PWM0;
            tick_d       = '0;
            mode_d       = MODE_STOPPING;
          end
        end
        MODE_SCANNING: begin
          if (req_d == REQ_OFF) begin
            desc_d.burst = BURST_STOP;
            tick_d       = '0;
            mode_d       = MODE_STOPPING;
          end else if (in_item_i.cmd == CMD_BYTE) begin
            // Skip the header, store four sample bytes, decode on the fifth
            if (hdr_q < HEADER_LEN) begin
              hdr_d = hdr_q + 3'd1;
            end else if (smp_q < 3'd4) begin
              smp_we = 1'b1;
              smp_d  = smp_q + 3'd1;
            end else begin
              smp_d = '0;
              if (dec_quality >= quality_min_q && dec_distance >= distance_min_q) begin
                desc_d.burst    = BURST_MEAS;
                desc_d.quality  = dec_quality;
                desc_d.angle    = dec_angle;
                desc_d.distance = dec_distance;
              end
            end
          end
        end
        default: begin
          // Stopping: wait out the motor run-down, then raise DTR
          if (CmpW'(tick_d) > CmpW'(stop_delay_q)) begin
            desc_d.burst = BURST_DTR_SET;
            mode_d       = MODE_OFF;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STOPPING;
      req_q  <= REQ_NONE;
      tick_q <= '0;
      hdr_q  <= '0;
      smp_q  <= '0;
    end else begin
      mode_q <= mode_d;
      req_q  <= req_d;
      tick_q <= tick_d;
      hdr_q  <= hdr_d;
      smp_q  <= smp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_we) begin
      smp_mem_q[smp_q[1:0]] <= in_item_i.rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Burst descriptor: load on an accepted item, advance per emitted result
  // ---------------------------------------------------------------------------
  always_comb begin
    desc_valid_d = desc_valid_q;
    idx_d        = idx_q;
    if (out_load) begin
      idx_d = idx_q + 3'd1;
      if (gen_item.last) begin
        desc_valid_d = 1'b0;
      end
    end
    if (in_acc) begin
      desc_valid_d = (desc_d.burst != BURST_NONE);
      idx_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      desc_valid_q <= desc_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      desc_q <= desc_d;
    end
  end

  llc_frame_gen u_frame_gen (
    .desc_i (desc_q),
    .idx_i  (idx_q),
    .item_o (gen_item)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold while stalled, drop valid once taken with nothing behind
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= gen_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

/* design/llc_frame_gen.sv */
// Frame generator: turns a burst descriptor and a position into one result item.
`default_nettype none

module llc_frame_gen (
  input  llc_pkg::llc_burst_t desc_i,
  input  logic [2:0]          idx_i,
  output llc_pkg::llc_out_t   item_o
);
  import llc_pkg::*;

  logic [2:0] idx_m1;
  logic [2:0] idx_m2;

  assign idx_m1 = idx_i - 3'd1;
  assign idx_m2 = idx_i - 3'd2;

  always_comb begin
    item_o           = '0;
    item_o.kind      = KIND_TX;
    case (desc_i.burst)
      BURST_START: begin
        if (idx_i == 3'd0) begin
          item_o.kind      = KIND_DTR;
          item_o.dtr_level = 1'b0;
        end else begin
          item_o.tx_byte = pwm_byte(idx_m1, desc_i.duty);
        end
        item_o.last = (idx_i == 3'd6);
      end
      BURST_PWM0: begin
        item_o.tx_byte = pwm_byte(idx_i, desc_i.duty);
        item_o.last    = (idx_i == 3'd5);
      end
      BURST_SCAN: begin
        item_o.tx_byte = (idx_i == 3'd0) ? SYNC_BYTE : SCAN_OPCODE;
        item_o.last    = (idx_i == 3'd1);
      end
      BURST_STOP: begin
        if (idx_i == 3'd0) begin
          item_o.tx_byte = SYNC_BYTE;
        end else if (idx_i == 3'd1) begin
          item_o.tx_byte = STOP_OPCODE;
        end else begin
          item_o.tx_byte = pwm_byte(idx_m2, desc_i.duty);
        end
        item_o.last = (idx_i == 3'd7);
      end
      BURST_DTR_SET: begin
        item_o.kind      = KIND_DTR;
        item_o.dtr_level = 1'b1;
        item_o.last      = 1'b1;
      end
      BURST_MEAS: begin
        item_o.kind     = KIND_MEAS;
        item_o.quality  = desc_i.quality;
        item_o.angle    = desc_i.angle;
        item_o.distance = desc_i.distance;
        item_o.last     = 1'b1;
      end
      default: begin
        item_o.last = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire
